FILE: design/tvms_pkg.sv
// Package for the thrust vector motion sequencer: payload and config types,
// motion mode codes, command codes and servo/throttle constants.
// No dependencies; every other design file imports it.
package tvms_pkg;

  typedef enum logic [2:0] {
    MM_NONE    = 3'd0,
    MM_RIGHT   = 3'd1,
    MM_LEFT    = 3'd2,
    MM_FORWARD = 3'd3,
    MM_UP      = 3'd4,
    MM_BRAKE   = 3'd5
  } mode_e;

  localparam logic [1:0] FM_MANUAL = 2'd0;
  localparam logic [1:0] FM_AUTO   = 2'd1;

  localparam logic [2:0] CMD_STOP    = 3'd0;
  localparam logic [2:0] CMD_FORWARD = 3'd1;
  localparam logic [2:0] CMD_LEFT    = 3'd2;
  localparam logic [2:0] CMD_RIGHT   = 3'd3;
  localparam logic [2:0] CMD_UP      = 3'd4;

  localparam logic [2:0] CFG_BRAKE_TICKS    = 3'd0;
  localparam logic [2:0] CFG_SERVO_TICKS    = 3'd1;
  localparam logic [2:0] CFG_THROTTLE_TICKS = 3'd2;
  localparam logic [2:0] CFG_THROTTLE_STEP  = 3'd3;
  localparam logic [2:0] CFG_IDLE_PULSE     = 3'd4;

  localparam logic [7:0]  SERVO_CENTER    = 8'd90;
  localparam logic [7:0]  SERVO_LEFT_GOAL = 8'd170;
  localparam logic [7:0]  SERVO_LOW_GOAL  = 8'd0;
  localparam logic [7:0]  SERVO_MAX       = 8'd180;
  localparam logic [11:0] MAX_PULSE       = 12'd4095;

  localparam logic [15:0] RST_BRAKE_TICKS    = 16'd100;
  localparam logic [15:0] RST_SERVO_TICKS    = 16'd15;
  localparam logic [15:0] RST_THROTTLE_TICKS = 16'd50;
  localparam logic [7:0]  RST_THROTTLE_STEP  = 8'd10;
  localparam logic [11:0] RST_IDLE_PULSE     = 12'd900;

  typedef struct packed {
    logic        anchor;
    logic [1:0]  flight_mode;
    logic [2:0]  manual_command;
    logic        want_right;
    logic        want_left;
    logic        want_forward;
    logic        want_up;
    logic [11:0] target_throttle;
  } in_t;

  typedef struct packed {
    logic [7:0]  left_servo_angle;
    logic [7:0]  right_servo_angle;
    logic [11:0] motor_pulse;
    logic [2:0]  motion_state;
    logic        busy_res;
  } out_t;

  typedef struct packed {
    logic [15:0] brake_ticks;
    logic [15:0] servo_step_ticks;
    logic [15:0] throttle_step_ticks;
    logic [7:0]  throttle_step;
    logic [11:0] idle_pulse;
  } cfg_t;

  // Sequence plan produced by the command decoder
  typedef struct packed {
    logic        mode_we;
    mode_e       mode;
    logic        plan_we;
    logic        servo;
    logic [7:0]  goal;
    logic        mirr;
    logic        settle;
    logic        spin;
    logic        brake;
    logic        spin_only;
  } plan_t;

endpackage

FILE: design/tvms_if.sv
// Handshake channel interfaces for the motion sequencer: command ticks in,
// results out, and the configuration write channel. Depends on tvms_pkg.
interface tvms_in_if;
  import tvms_pkg::*;
  logic valid;
  logic ready;
  in_t  payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface tvms_out_if;
  import tvms_pkg::*;
  logic valid;
  logic ready;
  out_t payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface tvms_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [15:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: design/tvms_decode.sv
// Command decoder: turns one tick's command snapshot and the current motion
// mode into a sequence plan. Pure logic; depends on tvms_pkg.
module tvms_decode (
  input  tvms_pkg::in_t   in_i,
  input  tvms_pkg::mode_e mode_i,
  output tvms_pkg::plan_t plan_o
);
  import tvms_pkg::*;

  always_comb begin : decode
    logic        tbl_ok;
    mode_e       tbl_mode;
    logic [7:0]  tbl_goal;
    logic        tbl_mirr;
    logic        tbl_settle;
    plan_t       p;

    p          = '0;
    p.mode     = mode_i;
    tbl_ok     = 1'b1;
    tbl_mode   = MM_NONE;
    tbl_goal   = SERVO_CENTER;
    tbl_mirr   = 1'b1;
    tbl_settle = 1'b0;

    unique case (in_i.manual_command)
      CMD_STOP: begin
        tbl_mode = MM_NONE;    tbl_goal = SERVO_CENTER;    tbl_mirr = 1'b1; tbl_settle = 1'b0;
      end
      CMD_FORWARD: begin
        tbl_mode = MM_FORWARD; tbl_goal = SERVO_LOW_GOAL;  tbl_mirr = 1'b1; tbl_settle = 1'b0;
      end
      CMD_LEFT: begin
        tbl_mode = MM_LEFT;    tbl_goal = SERVO_LEFT_GOAL; tbl_mirr = 1'b0; tbl_settle = 1'b1;
      end
      CMD_RIGHT: begin
        tbl_mode = MM_RIGHT;   tbl_goal = SERVO_LOW_GOAL;  tbl_mirr = 1'b0; tbl_settle = 1'b1;
      end
      CMD_UP: begin
        tbl_mode = MM_UP;      tbl_goal = SERVO_CENTER;    tbl_mirr = 1'b1; tbl_settle = 1'b1;
      end
      default: tbl_ok = 1'b0;
    endcase

    if (in_i.anchor) begin
      if (mode_i != MM_BRAKE) begin
        p.mode_we = 1'b1;
        p.mode    = MM_BRAKE;
        p.plan_we = 1'b1;
        p.settle  = 1'b1;
        p.brake   = 1'b1;
      end
    end else if (in_i.flight_mode == FM_MANUAL) begin
      if (tbl_ok) begin
        if (mode_i != tbl_mode) begin
          p.mode_we = 1'b1;
          p.mode    = tbl_mode;
          p.plan_we = 1'b1;
          p.servo   = 1'b1;
          p.goal    = tbl_goal;
          p.mirr    = tbl_mirr;
          p.settle  = tbl_settle;
          p.brake   = 1'b1;
        end else if (in_i.manual_command != CMD_STOP) begin
          p.plan_we   = 1'b1;
          p.spin      = 1'b1;
          p.spin_only = 1'b1;
        end
      end
    end else if (in_i.flight_mode == FM_AUTO) begin
      if (in_i.want_right) begin
        if (mode_i != MM_RIGHT) begin
          p.mode_we = 1'b1; p.mode = MM_RIGHT;
          p.plan_we = 1'b1; p.servo = 1'b1; p.goal = SERVO_LOW_GOAL;
          p.brake   = 1'b1;
        end
      end else if (in_i.want_left) begin
        if (mode_i != MM_LEFT) begin
          p.mode_we = 1'b1; p.mode = MM_LEFT;
          p.plan_we = 1'b1; p.servo = 1'b1; p.goal = SERVO_LEFT_GOAL;
          p.brake   = 1'b1;
        end
      end else if (in_i.want_forward) begin
        if (mode_i != MM_FORWARD) begin
          // level out only when coming from a yaw turn
          if (mode_i == MM_RIGHT || mode_i == MM_LEFT) begin
            p.plan_we = 1'b1; p.servo = 1'b1; p.goal = SERVO_LOW_GOAL;
            p.mirr    = 1'b1; p.brake = 1'b1;
          end
          p.mode_we = 1'b1; p.mode = MM_FORWARD;
        end
      end else if (in_i.want_up) begin
        p.plan_we = 1'b1;
        p.brake   = 1'b1;
        if (mode_i != MM_UP) begin
          p.mode_we = 1'b1; p.mode = MM_UP;
          p.servo   = 1'b1; p.goal = SERVO_CENTER; p.mirr = 1'b1; p.spin = 1'b1;
        end
      end
    end

    plan_o = p;
  end

endmodule

FILE: design/tvms_seq.sv
// Sequencer core: phase state, wait counter, servo and throttle ramps.
// Applies one tick per step_i. Depends on tvms_pkg and tvms_decode.
module tvms_seq (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           step_i,
  input  tvms_pkg::in_t  in_i,
  input  tvms_pkg::cfg_t cfg_i,
  output tvms_pkg::out_t res_o
);
  import tvms_pkg::*;

  typedef enum logic [2:0] {
    PH_IDLE, PH_BRAKE, PH_SERVO, PH_SETTLE, PH_SPIN
  } phase_e;

  phase_e      phase_q, phase_d;
  mode_e       mode_q, mode_d;
  logic [15:0] wait_q, wait_d;
  logic [7:0]  pos_q, pos_d;
  logic [7:0]  goal_q, goal_d;
  logic        mirr_q, mirr_d;
  logic        goal_mirr_q, goal_mirr_d;
  logic        servo_after_q, servo_after_d;
  logic        settle_after_q, settle_after_d;
  logic        spin_after_q, spin_after_d;
  logic [11:0] target_q, target_d;
  logic [11:0] thr_q, thr_d;
  plan_t       plan;

  logic [15:0] servo_reload, thr_reload;
  logic [7:0]  thr_inc;
  logic [12:0] thr_sum;

  tvms_decode u_decode (
    .in_i   (in_i),
    .mode_i (mode_q),
    .plan_o (plan)
  );

  // zero step registers act as one
  assign servo_reload = (cfg_i.servo_step_ticks == '0) ? '0 : cfg_i.servo_step_ticks - 16'd1;
  assign thr_reload   = (cfg_i.throttle_step_ticks == '0) ? '0
                                                           : cfg_i.throttle_step_ticks - 16'd1;
  assign thr_inc      = (cfg_i.throttle_step == '0) ? 8'd1 : cfg_i.throttle_step;

  always_comb begin : next_state
    phase_d        = phase_q;
    mode_d         = mode_q;
    wait_d         = wait_q;
    pos_d          = pos_q;
    goal_d         = goal_q;
    mirr_d         = mirr_q;
    goal_mirr_d    = goal_mirr_q;
    servo_after_d  = servo_after_q;
    settle_after_d = settle_after_q;
    spin_after_d   = spin_after_q;
    target_d       = target_q;
    thr_d          = thr_q;

    // accept a new command only between sequences
    if (phase_q == PH_IDLE) begin
      if (plan.mode_we) mode_d = plan.mode;
      if (plan.plan_we) begin
        servo_after_d  = plan.servo;
        if (plan.servo) goal_d = plan.goal;
        goal_mirr_d    = plan.mirr;
        settle_after_d = plan.settle;
        spin_after_d   = plan.spin;
        target_d       = in_i.target_throttle;
      end
      if (plan.brake) begin
        thr_d   = cfg_i.idle_pulse;
        phase_d = PH_BRAKE;
        wait_d  = cfg_i.brake_ticks;
      end
      if (plan.spin_only) begin
        phase_d = PH_SPIN;
        wait_d  = '0;
      end
    end

    thr_sum = {1'b0, thr_d} + {5'd0, thr_inc};

    if (phase_d != PH_IDLE) begin
      if (wait_d != '0) begin
        wait_d = wait_d - 16'd1;
      end else if (phase_d == PH_SERVO && pos_d != goal_d) begin
        pos_d  = (pos_d < goal_d) ? pos_d + 8'd1 : pos_d - 8'd1;
        wait_d = servo_reload;
      end else if (phase_d == PH_SPIN && target_d > thr_d) begin
        thr_d  = thr_sum[12] ? MAX_PULSE : thr_sum[11:0];
        wait_d = thr_reload;
      end else begin
        // hand over to the next planned phase
        if (phase_d == PH_BRAKE && servo_after_d) begin
          servo_after_d = 1'b0;
          if (pos_d != goal_d) mirr_d = goal_mirr_d;
          phase_d = PH_SERVO;
          wait_d  = '0;
        end else begin
          servo_after_d = 1'b0;
          if ((phase_d == PH_BRAKE || phase_d == PH_SERVO) && settle_after_d) begin
            settle_after_d = 1'b0;
            phase_d        = PH_SETTLE;
            wait_d         = cfg_i.brake_ticks;
          end else begin
            settle_after_d = 1'b0;
            if (phase_d != PH_SPIN && spin_after_d) begin
              spin_after_d = 1'b0;
              phase_d      = PH_SPIN;
              wait_d       = '0;
            end else begin
              spin_after_d = 1'b0;
              phase_d      = PH_IDLE;
              wait_d       = '0;
            end
          end
        end
      end
    end
  end

  always_comb begin : result
    res_o.left_servo_angle  = mirr_d ? SERVO_MAX - pos_d : pos_d;
    res_o.right_servo_angle = pos_d;
    res_o.motor_pulse       = thr_d;
    res_o.motion_state      = mode_d;
    res_o.busy_res          = (phase_d != PH_IDLE);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q        <= PH_IDLE;
      mode_q         <= MM_NONE;
      wait_q         <= '0;
      pos_q          <= SERVO_CENTER;
      goal_q         <= SERVO_CENTER;
      mirr_q         <= 1'b1;
      goal_mirr_q    <= 1'b1;
      servo_after_q  <= 1'b0;
      settle_after_q <= 1'b0;
      spin_after_q   <= 1'b0;
      target_q       <= '0;
      thr_q          <= RST_IDLE_PULSE;
    end else if (step_i) begin
      phase_q        <= phase_d;
      mode_q         <= mode_d;
      wait_q         <= wait_d;
      pos_q          <= pos_d;
      goal_q         <= goal_d;
      mirr_q         <= mirr_d;
      goal_mirr_q    <= goal_mirr_d;
      servo_after_q  <= servo_after_d;
      settle_after_q <= settle_after_d;
      spin_after_q   <= spin_after_d;
      target_q       <= target_d;
      thr_q          <= thr_d;
    end
  end

`ifndef NO_ASSERTIONS
  a_idle_no_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_IDLE) |-> (wait_q == '0))
    else $error("wait counter running while idle");

  a_idle_no_plan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_IDLE) |-> (!servo_after_q && !settle_after_q && !spin_after_q))
    else $error("pending phase flags while idle");

  a_servo_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= SERVO_MAX)
    else $error("servo position out of range");

  a_servo_slew: assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> ($stable(pos_q) || pos_q == $past(pos_q) + 8'd1 || pos_q == $past(pos_q) - 8'd1))
    else $error("servo moved more than one degree in a tick");

  a_servo_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_SERVO) |-> !servo_after_q)
    else $error("servo ramp still pending while ramping");
`endif

endmodule

FILE: design/thrust_vector_motion_sequencer_top.sv
// Thrust vector motion sequencer, top level. Each tick transaction passes an input
// register, then a result register, before its result is presented. Throughput: one
// tick transaction per cycle, set by the single-pass sequencer logic between the two
// registers; input stalls only while both registers are full and the result is not
// taken.
// Reset (rst_ni low, asynchronous): pipeline empty, config at defaults, servos
// at 90 degrees level, throttle at 900 us idle, no sequence running.
module thrust_vector_motion_sequencer_top (
  input  logic              clk_i,
  input  logic              rst_ni,
  tvms_in_if.sink           in_i,
  tvms_cfg_if.sink          cfg_i,
  tvms_out_if.source        out_o
);
  import tvms_pkg::*;

  cfg_t cfg_q;
  logic in_valid_q;
  in_t  in_data_q;
  logic out_valid_q;
  out_t out_data_q;
  out_t res;
  logic advance;
  logic step;

  // Configuration: always ready, writes to unknown indexes are dropped.
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.brake_ticks         <= RST_BRAKE_TICKS;
      cfg_q.servo_step_ticks    <= RST_SERVO_TICKS;
      cfg_q.throttle_step_ticks <= RST_THROTTLE_TICKS;
      cfg_q.throttle_step       <= RST_THROTTLE_STEP;
      cfg_q.idle_pulse          <= RST_IDLE_PULSE;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        CFG_BRAKE_TICKS:    cfg_q.brake_ticks         <= cfg_i.data;
        CFG_SERVO_TICKS:    cfg_q.servo_step_ticks    <= cfg_i.data;
        CFG_THROTTLE_TICKS: cfg_q.throttle_step_ticks <= cfg_i.data;
        CFG_THROTTLE_STEP:  cfg_q.throttle_step       <= cfg_i.data[7:0];
        CFG_IDLE_PULSE:     cfg_q.idle_pulse          <= cfg_i.data[11:0];
        default: ;
      endcase
    end
  end

  // Pipeline control: the result register advances when empty or taken;
  // the input register refills whenever its transaction moves on.
  assign advance    = !out_valid_q || out_o.ready;
  assign step       = in_valid_q && advance;
  assign in_i.ready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_i.ready) in_valid_q  <= in_i.valid;
      if (advance)    out_valid_q <= in_valid_q;
    end
  end

  // Payload registers: hold unless loaded.
  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) in_data_q  <= in_i.payload;
    if (step)                     out_data_q <= res;
  end

  // Sequencer: commits one tick of state and produces its result on step.
  tvms_seq u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .in_i   (in_data_q),
    .cfg_i  (cfg_q),
    .res_o  (res)
  );

  assign out_o.valid   = out_valid_q;
  assign out_o.payload = out_data_q;

endmodule

FILE: tb/tb.sv
// Self-checking testbench for thrust_vector_motion_sequencer_top: drives tick
// transactions, writes the five config registers and checks every result
// against a cycle-free predictor. Depends on tvms_pkg, tvms_if and the top level.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import tvms_pkg::*;

  // Input codes that the block must ignore
  localparam logic [1:0] FM_UNUSED_A   = 2'd2;
  localparam logic [1:0] FM_UNUSED_B   = 2'd3;
  localparam logic [2:0] CMD_UNUSED_LO = 3'd5;
  localparam logic [2:0] CMD_UNUSED    = 3'd6;
  localparam logic [2:0] CMD_UNUSED_HI = 3'd7;

  // Cycles with no transaction on any channel before the run is declared hung
  localparam int QUIET_LIMIT = 2000;
  // Length of the output hold-off that backs the pipeline up
  localparam int HOLD_CYCLES = 300;
  // Tick transactions to send over the whole run
  localparam int ITEMS = 1500;

  typedef enum logic [2:0] {
    SEQ_IDLE, SEQ_BRAKE, SEQ_SERVO, SEQ_SETTLE, SEQ_SPIN
  } seq_phase_e;

  // Predicts the result of each tick and holds the results still to come.
  class motion_scoreboard;
    logic [15:0] brake_ticks, servo_ticks, throttle_ticks;
    logic [7:0]  throttle_step;
    logic [11:0] idle_pulse;

    mode_e       motion_mode;
    logic [7:0]  servo_pos, servo_goal;
    bit          left_mirrored, goal_mirrored;
    logic [11:0] throttle, spin_target;
    seq_phase_e  phase;
    logic [15:0] wait_left;
    bit          servo_next, settle_next, spin_next;

    out_t        expected_q[$];
    int          errors;

    function new();
      brake_ticks    = RST_BRAKE_TICKS;
      servo_ticks    = RST_SERVO_TICKS;
      throttle_ticks = RST_THROTTLE_TICKS;
      throttle_step  = RST_THROTTLE_STEP;
      idle_pulse     = RST_IDLE_PULSE;
      motion_mode    = MM_NONE;
      servo_pos      = SERVO_CENTER;
      servo_goal     = SERVO_CENTER;
      left_mirrored  = 1'b1;
      goal_mirrored  = 1'b1;
      throttle       = RST_IDLE_PULSE;
      spin_target    = '0;
      phase          = SEQ_IDLE;
      wait_left      = '0;
      servo_next     = 1'b0;
      settle_next    = 1'b0;
      spin_next      = 1'b0;
      errors         = 0;
    endfunction

    function void set_reg(logic [2:0] idx, logic [15:0] d);
      case (idx)
        CFG_BRAKE_TICKS:    brake_ticks    = d;
        CFG_SERVO_TICKS:    servo_ticks    = d;
        CFG_THROTTLE_TICKS: throttle_ticks = d;
        CFG_THROTTLE_STEP:  throttle_step  = d[7:0];
        CFG_IDLE_PULSE:     idle_pulse     = d[11:0];
        default: ;
      endcase
    endfunction

    function bit is_idle();
      return phase == SEQ_IDLE;
    endfunction

    // A zero step period behaves as one tick
    function logic [15:0] hold_after(logic [15:0] period);
      return (period == 16'd0) ? 16'd0 : period - 16'd1;
    endfunction

    function void plan_seq(bit servo, logic [7:0] goal, bit mirr, bit settle, bit spin,
                           logic [11:0] target);
      servo_next    = servo;
      if (servo) servo_goal = goal;
      goal_mirrored = mirr;
      settle_next   = settle;
      spin_next     = spin;
      spin_target   = target;
    endfunction

    function void start_brake();
      throttle  = idle_pulse;
      phase     = SEQ_BRAKE;
      wait_left = brake_ticks;
    endfunction

    function void next_phase();
      if (phase == SEQ_BRAKE && servo_next) begin
        servo_next = 1'b0;
        phase      = SEQ_SERVO;
        wait_left  = '0;
        // mirroring only changes when the servo actually has to move
        if (servo_pos != servo_goal) left_mirrored = goal_mirrored;
        return;
      end
      servo_next = 1'b0;
      if ((phase == SEQ_BRAKE || phase == SEQ_SERVO) && settle_next) begin
        settle_next = 1'b0;
        phase       = SEQ_SETTLE;
        wait_left   = brake_ticks;
        return;
      end
      settle_next = 1'b0;
      if (phase != SEQ_SPIN && spin_next) begin
        spin_next = 1'b0;
        phase     = SEQ_SPIN;
        wait_left = '0;
        return;
      end
      spin_next = 1'b0;
      phase     = SEQ_IDLE;
      wait_left = '0;
    endfunction

    function void run_phase();
      logic [12:0] sum;
      if (phase == SEQ_IDLE) return;
      if (wait_left != 16'd0) begin
        wait_left = wait_left - 16'd1;
        return;
      end
      case (phase)
        SEQ_SERVO: begin
          if (servo_pos == servo_goal) begin
            next_phase();
          end else begin
            if (servo_pos < servo_goal) servo_pos = servo_pos + 8'd1;
            else servo_pos = servo_pos - 8'd1;
            wait_left = hold_after(servo_ticks);
          end
        end
        SEQ_SPIN: begin
          if (spin_target > throttle) begin
            sum = 13'(throttle) + 13'((throttle_step == 8'd0) ? 8'd1 : throttle_step);
            throttle  = (sum > 13'(MAX_PULSE)) ? MAX_PULSE : sum[11:0];
            wait_left = hold_after(throttle_ticks);
          end else begin
            next_phase();
          end
        end
        default: next_phase();
      endcase
    endfunction

    function void manual_cmd(logic [2:0] cmd, logic [11:0] target);
      mode_e      m;
      logic [7:0] goal;
      bit         mirr, settle;
      case (cmd)
        CMD_STOP:    begin m = MM_NONE;    goal = SERVO_CENTER;    mirr = 1; settle = 0; end
        CMD_FORWARD: begin m = MM_FORWARD; goal = SERVO_LOW_GOAL;  mirr = 1; settle = 0; end
        CMD_LEFT:    begin m = MM_LEFT;    goal = SERVO_LEFT_GOAL; mirr = 0; settle = 1; end
        CMD_RIGHT:   begin m = MM_RIGHT;   goal = SERVO_LOW_GOAL;  mirr = 0; settle = 1; end
        CMD_UP:      begin m = MM_UP;      goal = SERVO_CENTER;    mirr = 1; settle = 1; end
        default: return;
      endcase
      if (motion_mode != m) begin
        motion_mode = m;
        plan_seq(1, goal, mirr, settle, 0, target);
        start_brake();
      end else if (cmd != CMD_STOP) begin
        // same direction again: spin up only
        plan_seq(0, '0, 0, 0, 1, target);
        phase     = SEQ_SPIN;
        wait_left = '0;
      end
    endfunction

    function void autopilot_cmd(in_t t);
      if (t.want_right) begin
        if (motion_mode != MM_RIGHT) begin
          motion_mode = MM_RIGHT;
          plan_seq(1, SERVO_LOW_GOAL, 0, 0, 0, t.target_throttle);
          start_brake();
        end
      end else if (t.want_left) begin
        if (motion_mode != MM_LEFT) begin
          motion_mode = MM_LEFT;
          plan_seq(1, SERVO_LEFT_GOAL, 0, 0, 0, t.target_throttle);
          start_brake();
        end
      end else if (t.want_forward) begin
        if (motion_mode != MM_FORWARD) begin
          if (motion_mode == MM_RIGHT || motion_mode == MM_LEFT) begin
            plan_seq(1, SERVO_LOW_GOAL, 1, 0, 0, t.target_throttle);
            start_brake();
          end
          motion_mode = MM_FORWARD;
        end
      end else if (t.want_up) begin
        if (motion_mode != MM_UP) begin
          plan_seq(1, SERVO_CENTER, 1, 0, 1, t.target_throttle);
          motion_mode = MM_UP;
        end else begin
          plan_seq(0, '0, 0, 0, 0, t.target_throttle);
        end
        start_brake();
      end
    endfunction

    // Note an accepted tick: decode it if no sequence runs, advance one tick
    function void note_tick(in_t t);
      out_t want;
      if (phase == SEQ_IDLE) begin
        if (t.anchor) begin
          if (motion_mode != MM_BRAKE) begin
            motion_mode = MM_BRAKE;
            plan_seq(0, '0, 0, 1, 0, t.target_throttle);
            start_brake();
          end
        end else if (t.flight_mode == FM_MANUAL) begin
          manual_cmd(t.manual_command, t.target_throttle);
        end else if (t.flight_mode == FM_AUTO) begin
          autopilot_cmd(t);
        end
      end
      run_phase();
      want.left_servo_angle  = left_mirrored ? SERVO_MAX - servo_pos : servo_pos;
      want.right_servo_angle = servo_pos;
      want.motor_pulse       = throttle;
      want.motion_state      = motion_mode;
      want.busy_res          = (phase != SEQ_IDLE);
      expected_q.push_back(want);
    endfunction

    function void compare_field(string name, logic [11:0] want, logic [11:0] got);
      if (got !== want) begin
        errors++;
        if (errors <= 60)
          $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
      end
    endfunction

    function void check_result(out_t got);
      out_t want;
      if (expected_q.size() == 0) begin
        errors++;
        if (errors <= 60)
          $display("%0t: result with nothing expected: expected none, actual %h", $time, got);
        return;
      end
      want = expected_q.pop_front();
      compare_field("left_servo_angle", 12'(want.left_servo_angle),
                    12'(got.left_servo_angle));
      compare_field("right_servo_angle", 12'(want.right_servo_angle),
                    12'(got.right_servo_angle));
      compare_field("motor_pulse", want.motor_pulse, got.motor_pulse);
      compare_field("motion_state", 12'(want.motion_state), 12'(got.motion_state));
      compare_field("busy_res", 12'(want.busy_res), 12'(got.busy_res));
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;

  tvms_in_if  in_if ();
  tvms_cfg_if cfg_if ();
  tvms_out_if out_if ();

  thrust_vector_motion_sequencer_top DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .cfg_i  (cfg_if),
    .out_o  (out_if)
  );

  motion_scoreboard sb;
  bit   no_gaps;      // suppress random idling on both sides
  bit   pressure_go;  // start the long output hold-off
  bit   holding;
  in_t  last_cmd;
  bit   have_last;
  int   quiet_cycles;
  int   sent;         // tick transactions accepted so far

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Receiver: drop ready now and then, or for a long stretch under pressure
  always @(posedge clk_i) begin
    out_if.ready <= !holding && (no_gaps || $urandom_range(99) >= 6);
  end

  // Hold the output off long enough for the pipeline to fill and stall input
  initial begin
    holding = 1'b0;
    wait (pressure_go);
    holding = 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk_i);
    holding = 1'b0;
  end

  // Check every result transaction against the oldest prediction
  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid === 1'b1 && out_if.ready === 1'b1)
      sb.check_result(out_if.payload);
  end

  // Watchdog: end the run when no channel moves a transaction for too long
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
          (cfg_if.valid && cfg_if.ready))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("status: fail");
        $finish;
      end
    end
  end

  function automatic in_t tick_of(bit a, logic [1:0] fm, logic [2:0] mc,
                                  bit wr, bit wl, bit wf, bit wu, logic [11:0] tgt);
    in_t t;
    t.anchor          = a;
    t.flight_mode     = fm;
    t.manual_command  = mc;
    t.want_right      = wr;
    t.want_left       = wl;
    t.want_forward    = wf;
    t.want_up         = wu;
    t.target_throttle = tgt;
    return t;
  endfunction

  // Fully random tick, used while a sequence runs and inputs are ignored
  function automatic in_t any_tick();
    logic [31:0] raw;
    raw = $urandom;
    return raw[$bits(in_t)-1:0];
  endfunction

  // Random command for an idle sequencer; targets mostly close to idle pulse
  function automatic in_t make_command();
    in_t t;
    int unsigned r, level;
    t = any_tick();
    if (have_last && $urandom_range(99) < 30) begin
      // repeat the last command to reach the same-mode paths
      t = last_cmd;
    end else begin
      t.anchor = ($urandom_range(99) < 8);
      r = $urandom_range(99);
      if (r < 48) t.flight_mode = FM_MANUAL;
      else if (r < 95) t.flight_mode = FM_AUTO;
      else t.flight_mode = 2'($urandom_range(FM_UNUSED_A, FM_UNUSED_B));
      if ($urandom_range(99) < 6)
        t.manual_command = 3'($urandom_range(CMD_UNUSED_LO, CMD_UNUSED_HI));
      else
        t.manual_command = 3'($urandom_range(CMD_STOP, CMD_UP));
      t.want_right   = ($urandom_range(3) == 0);
      t.want_left    = ($urandom_range(3) == 0);
      t.want_forward = ($urandom_range(3) == 0);
      t.want_up      = ($urandom_range(3) == 0);
      if ($urandom_range(4) != 0) begin
        case ($urandom_range(3))
          0: t.want_right = 1'b1;
          1: t.want_left = 1'b1;
          2: t.want_forward = 1'b1;
          default: t.want_up = 1'b1;
        endcase
      end
    end
    level = sb.idle_pulse;
    r = $urandom_range(99);
    if (r < 70) level = level + $urandom_range(0, 80);
    else if (r < 85) level = $urandom_range(0, level);
    else if (r < 97) level = level + $urandom_range(0, 400);
    else level = $urandom_range(0, MAX_PULSE);
    t.target_throttle = (level > MAX_PULSE) ? MAX_PULSE : level[11:0];
    last_cmd  = t;
    have_last = 1'b1;
    return t;
  endfunction

  // Offer one tick, with an occasional random gap, and note it once accepted
  task automatic send_tick(in_t t);
    while (!no_gaps && $urandom_range(99) < 6) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid   <= 1'b1;
    in_if.payload <= t;
    do @(posedge clk_i); while (in_if.ready !== 1'b1);
    sb.note_tick(t);
    sent++;
  endtask

  // Send a command, then filler ticks until its sequence has finished
  task automatic issue(in_t t);
    send_tick(t);
    while (!sb.is_idle()) send_tick(any_tick());
  endtask

  // Drop valid and wait until every predicted result has been delivered
  task automatic drain();
    in_if.valid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic load_config(logic [15:0] brake, logic [15:0] servo, logic [15:0] thr_ticks,
                             logic [7:0] thr_step, logic [11:0] idle);
    logic [2:0]  regs[5];
    logic [15:0] vals[5];
    regs = '{CFG_BRAKE_TICKS, CFG_SERVO_TICKS, CFG_THROTTLE_TICKS, CFG_THROTTLE_STEP,
             CFG_IDLE_PULSE};
    vals = '{brake, servo, thr_ticks, 16'(thr_step), 16'(idle)};
    drain();
    for (int i = 0; i < 5; i++) begin
      cfg_if.valid <= 1'b1;
      cfg_if.index <= regs[i];
      cfg_if.data  <= vals[i];
      do @(posedge clk_i); while (cfg_if.ready !== 1'b1);
      sb.set_reg(regs[i], vals[i]);
    end
    cfg_if.valid <= 1'b0;
  endtask

  initial begin
    in_if.valid    = 1'b0;
    in_if.payload  = '0;
    cfg_if.valid   = 1'b0;
    cfg_if.index   = CFG_BRAKE_TICKS;
    cfg_if.data    = '0;
    out_if.ready   = 1'b0;
    rst_ni         = 1'b0;
    no_gaps        = 1'b0;
    pressure_go    = 1'b0;
    have_last      = 1'b0;
    quiet_cycles   = 0;
    sent           = 0;
    sb = new();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset config: anchor brake and settle, then up with the servo already level and a spin
    issue(tick_of(1, FM_MANUAL, CMD_STOP, 0, 0, 0, 0, 12'd3000));
    issue(tick_of(0, FM_AUTO, CMD_STOP, 0, 0, 0, 1, 12'd915));

    // Short timing: stop, up, left, forward out of a turn, right and forward with the
    // servo at goal, ignored codes, up ramp and spin, up again, anchor
    load_config(16'd2, 16'd1, 16'd2, 8'd7, 12'd1000);
    issue(tick_of(0, FM_MANUAL, CMD_STOP, 1, 1, 1, 1, 12'd4095));
    issue(tick_of(0, FM_MANUAL, CMD_STOP, 0, 0, 0, 0, 12'd0));
    issue(tick_of(0, FM_MANUAL, CMD_UP, 0, 0, 0, 0, 12'd0));
    issue(tick_of(0, FM_MANUAL, CMD_UP, 0, 0, 0, 0, 12'd1030));
    issue(tick_of(0, FM_AUTO, CMD_STOP, 0, 1, 0, 0, 12'd0));
    issue(tick_of(0, FM_AUTO, CMD_STOP, 0, 1, 0, 0, 12'd0));
    issue(tick_of(0, FM_AUTO, CMD_STOP, 0, 0, 1, 1, 12'd0));
    issue(tick_of(0, FM_AUTO, CMD_STOP, 0, 0, 1, 0, 12'd0));
    issue(tick_of(0, FM_AUTO, CMD_LEFT, 1, 1, 0, 0, 12'd0));
    issue(tick_of(0, FM_AUTO, CMD_STOP, 0, 0, 1, 0, 12'd0));
    issue(tick_of(0, FM_MANUAL, CMD_UNUSED, 1, 1, 1, 1, 12'd2048));
    issue(tick_of(0, FM_UNUSED_A, CMD_STOP, 1, 1, 1, 1, 12'd2048));
    issue(tick_of(0, FM_UNUSED_B, CMD_RIGHT, 1, 0, 0, 1, 12'd2048));
    issue(tick_of(0, FM_MANUAL, CMD_RIGHT, 0, 0, 0, 0, 12'd0));
    issue(tick_of(0, FM_MANUAL, CMD_RIGHT, 0, 0, 0, 0, 12'd1020));
    issue(tick_of(0, FM_AUTO, CMD_STOP, 0, 0, 0, 1, 12'd1050));
    issue(tick_of(0, FM_AUTO, CMD_STOP, 0, 0, 1, 0, 12'd0));
    issue(tick_of(0, FM_AUTO, CMD_STOP, 0, 0, 0, 1, 12'd1200));
    issue(tick_of(0, FM_AUTO, CMD_STOP, 0, 0, 0, 1, 12'd1200));
    issue(tick_of(0, FM_AUTO, CMD_STOP, 0, 0, 0, 0, 12'd1200));
    issue(tick_of(1, FM_AUTO, CMD_STOP, 1, 0, 0, 0, 12'd0));
    issue(tick_of(1, FM_MANUAL, CMD_UP, 0, 0, 0, 0, 12'd0));

    // Zero step registers act as one; forward from right with servo at goal
    load_config(16'd0, 16'd0, 16'd0, 8'd0, 12'd0);
    issue(tick_of(0, FM_MANUAL, CMD_RIGHT, 0, 0, 0, 0, 12'd5));
    issue(tick_of(0, FM_MANUAL, CMD_RIGHT, 0, 0, 0, 0, 12'd5));
    issue(tick_of(0, FM_AUTO, CMD_STOP, 0, 0, 1, 0, 12'd0));

    // Largest throttle step: the spin saturates at the top pulse
    load_config(16'd1, 16'd1, 16'd1, 8'hFF, 12'd3900);
    issue(tick_of(0, FM_AUTO, CMD_STOP, 0, 0, 0, 1, 12'hFFF));

    // Random commands; first stretch without any idling
    load_config(16'd3, 16'd1, 16'd1, 8'd20, 12'd900);
    no_gaps = 1'b1;
    do issue(make_command()); while (sent < ITEMS - 350);
    no_gaps = 1'b0;

    load_config(16'd0, 16'd2, 16'd3, 8'd255, 12'd0);
    pressure_go = 1'b1;
    do issue(make_command()); while (sent < ITEMS - 200);

    load_config(16'd1, 16'd0, 16'd0, 8'd0, 12'd4095);
    do issue(make_command()); while (sent < ITEMS - 100);

    repeat (2) begin
      load_config(16'($urandom_range(0, 6)), 16'($urandom_range(0, 2)),
                  16'($urandom_range(0, 3)), 8'($urandom_range(16, 255)),
                  12'($urandom_range(0, MAX_PULSE)));
      do issue(make_command()); while (sent < ITEMS - 50);
    end
    do issue(make_command()); while (sent < ITEMS);

    drain();
    if (sb.errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

FILE: filelist.f
design/tvms_pkg.sv
design/tvms_if.sv
design/tvms_decode.sv
design/tvms_seq.sv
design/thrust_vector_motion_sequencer_top.sv
tb/tb.sv
